>>> rtl/usart_baud_divisor_defines.svh
`ifndef USART_BAUD_DIVISOR_DEFINES_SVH
`define USART_BAUD_DIVISOR_DEFINES_SVH

// Clocked assertion, inactive while reset is asserted.
`define UBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define UBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/ubd_pkg.sv
`default_nettype none

package ubd_pkg;

  // Field widths
  localparam int unsigned CLK_W  = 28;
  localparam int unsigned BAUD_W = 25;
  localparam int unsigned MANT_W = 25;
  localparam int unsigned FRAC_W = 4;
  localparam int unsigned WORD_W = MANT_W + FRAC_W;

  // Divider: 32-bit dividend/quotient, two quotient bits per stage
  localparam int unsigned DIVD_W             = 32;
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES         = DIVD_W / DIV_BITS_PER_STAGE;

  // Pipeline stage positions
  localparam int unsigned ST_IN    = 0;
  localparam int unsigned ST_MUL   = DIV_STAGES + 1;
  localparam int unsigned ST_REM   = DIV_STAGES + 2;
  localparam int unsigned ST_OUT   = DIV_STAGES + 3;
  localparam int unsigned N_STAGES = DIV_STAGES + 4;

  // Quotient / 100 fits 26 bits
  localparam int unsigned QM_W = 26;
  localparam int unsigned REM_W = 7;
  localparam int unsigned FV_W  = 11;

  localparam logic [4:0]        CLK_SCALE   = 5'd25;
  localparam logic [30:0]       RECIP_100   = 31'h51EB851F;
  localparam int unsigned       RECIP_SHIFT = 37;
  localparam logic [REM_W-1:0]  DEC_SCALE   = 7'd100;
  localparam logic [FV_W-1:0]   FRAC_BIAS   = 11'd50;
  localparam logic [FV_W-1:0]   FRAC_RECIP  = 11'd1311;
  localparam int unsigned       FRAC_SHIFT  = 17;
  localparam logic [FRAC_W-1:0] MASK_BY8    = 4'h7;
  localparam logic [FRAC_W-1:0] MASK_BY16   = 4'hF;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_OVERSAMPLE = 1'b0;

  typedef struct packed {
    logic [DIVD_W-1:0] dq;   // dividend shifts out on top, quotient in at bottom
    logic [BAUD_W-1:0] r;
    logic [BAUD_W-1:0] b;
    logic              err;
    logic              by8;
  } div_t;

  // Restoring division, DIV_BITS_PER_STAGE quotient bits
  function automatic div_t div_step(div_t x);
    div_t          y;
    logic [BAUD_W:0] trial;
    logic [BAUD_W:0] bext;
    logic          ge;
    y = x;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      trial = {y.r, y.dq[DIVD_W-1]};
      bext  = {1'b0, y.b};
      ge    = (trial >= bext);
      if (ge) begin
        trial = trial - bext;
      end
      y.r  = trial[BAUD_W-1:0];
      y.dq = {y.dq[DIVD_W-2:0], ge};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ubd_req_if.sv
`default_nettype none

interface ubd_req_if import ubd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CLK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0] baud_rate;

  modport source (output valid, clock_hz, baud_rate, input ready);
  modport sink   (input valid, clock_hz, baud_rate, output ready);
endinterface

`default_nettype wire

>>> rtl/ubd_rsp_if.sv
`default_nettype none

interface ubd_rsp_if import ubd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MANT_W-1:0] mantissa;
  logic [FRAC_W-1:0] fraction;
  logic [WORD_W-1:0] brr_word;
  logic              divide_error;

  modport source (output valid, mantissa, fraction, brr_word, divide_error, input ready);
  modport sink   (input valid, mantissa, fraction, brr_word, divide_error, output ready);
endinterface

`default_nettype wire

>>> rtl/usart_baud_divisor.sv
// USART baud divisor: for each request (clock_hz, baud_rate) returns the
// mantissa/fraction baud register word, with the fraction rounded to 3 bits
// (oversampling by 8) or 4 bits (by 16) and a rounding overflow dropped.
// A zero baud rate sets divide_error and zeroes the other fields. The block
// takes one request per cycle, unless backpressure stalls the pipeline,
// and answers in order through 20 register stages: one input stage, a
// 16-stage restoring divider retiring two quotient bits per stage, then
// multiply-by-reciprocal, remainder and rounding stages, the last of
// which is the output register. Each stage stalls only when it is
// full and the one after it cannot move, so bubbles are squeezed out under
// backpressure. Oversampling mode is set through register 0 of the APB
// port (bit 0, reset 0) and travels with each request.
`default_nettype none

module usart_baud_divisor import ubd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ubd_req_if.sink           req_i,
  ubd_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic [REM_W-1:0]  q;
    logic [QM_W-1:0]   mant;
    logic              err;
    logic              by8;
  } mul_t;

  typedef struct packed {
    logic [FV_W-1:0]   fv;
    logic [MANT_W-1:0] mant;
    logic              err;
    logic              by8;
  } rem_t;

  typedef struct packed {
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic              err;
  } out_t;

  // Configuration
  logic by8_q;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_OVERSAMPLE);
  assign prdata  = reg_hit ? {{(APB_DW-1){1'b0}}, by8_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      by8_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      by8_q <= pwdata[0];
    end
  end

  // Stage flow control
  logic [N_STAGES-1:0] v_q, v_d, en;

  always_comb begin
    en[N_STAGES-1] = !v_q[N_STAGES-1] || rsp_o.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? req_i.valid : v_q[0];
    for (int k = 1; k < N_STAGES; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  assign req_i.ready = en[ST_IN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Entry: numerator 25*clock, halved (by 8) or quartered (by 16)
  logic [CLK_W+4:0] num;
  div_t             entry_d;
  div_t             div_q [DIV_STAGES+1];

  assign num = {5'b0, req_i.clock_hz} * {{CLK_W{1'b0}}, CLK_SCALE};

  always_comb begin
    entry_d.dq  = by8_q ? num[CLK_W+4:1] : {1'b0, num[CLK_W+4:2]};
    entry_d.r   = '0;
    entry_d.b   = req_i.baud_rate;
    entry_d.err = (req_i.baud_rate == '0);
    entry_d.by8 = by8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      div_q[0] <= entry_d;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        div_q[k] <= div_step(div_q[k-1]);
      end
    end
  end

  // Quotient / 100 by reciprocal multiply
  logic [DIVD_W+30:0] recip_prod;
  mul_t               mul_d, mul_q;

  assign recip_prod = {31'b0, div_q[DIV_STAGES].dq} * {{DIVD_W{1'b0}}, RECIP_100};

  always_comb begin
    mul_d.q    = div_q[DIV_STAGES].dq[REM_W-1:0];
    mul_d.mant = recip_prod[RECIP_SHIFT +: QM_W];
    mul_d.err  = div_q[DIV_STAGES].err;
    mul_d.by8  = div_q[DIV_STAGES].by8;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      mul_q <= mul_d;
    end
  end

  // Remainder (0..99) only needs the low bits of the difference
  logic [QM_W+6:0]  dec_prod;
  logic [REM_W-1:0] rem;
  rem_t             rem_d, rem_q;

  assign dec_prod = {7'b0, mul_q.mant} * {{QM_W{1'b0}}, DEC_SCALE};
  assign rem      = mul_q.q - dec_prod[REM_W-1:0];

  always_comb begin
    rem_d.fv   = mul_q.by8 ? ({1'b0, rem, 3'b000} + FRAC_BIAS)
                           : ({rem, 4'b0000} + FRAC_BIAS);
    rem_d.mant = mul_q.mant[MANT_W-1:0];
    rem_d.err  = mul_q.err;
    rem_d.by8  = mul_q.by8;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_REM]) begin
      rem_q <= rem_d;
    end
  end

  // Rounded fraction: fv / 100 via reciprocal, exact for fv below 1700
  logic [2*FV_W-1:0] frac_prod;
  logic [FRAC_W-1:0] frac_raw;
  out_t              out_d, out_q;

  assign frac_prod = {{FV_W{1'b0}}, rem_q.fv} * {{FV_W{1'b0}}, FRAC_RECIP};
  assign frac_raw  = frac_prod[FRAC_SHIFT +: FRAC_W];

  always_comb begin
    out_d.err  = rem_q.err;
    out_d.mant = rem_q.err ? '0 : rem_q.mant;
    out_d.frac = rem_q.err ? '0 : (frac_raw & (rem_q.by8 ? MASK_BY8 : MASK_BY16));
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid        = v_q[ST_OUT];
  assign rsp_o.mantissa     = out_q.mant;
  assign rsp_o.fraction     = out_q.frac;
  assign rsp_o.brr_word     = {out_q.mant, out_q.frac};
  assign rsp_o.divide_error = out_q.err;

endmodule

`default_nettype wire

>>> rtl/ubd_checker.sv
`default_nettype none
`include "usart_baud_divisor_defines.svh"

module ubd_checker import ubd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ubd_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              pwrite,
  input  logic [APB_DW-1:0] prdata
);

  `UBD_ASSERT(a_err_zeroes, rsp_o.valid && rsp_o.divide_error |-> rsp_o.mantissa == '0 && rsp_o.fraction == '0 && rsp_o.brr_word == '0, "error result has nonzero fields")

  `UBD_ASSERT(a_word_packing, rsp_o.valid |-> rsp_o.brr_word[WORD_W-1:FRAC_W] == rsp_o.mantissa && rsp_o.brr_word[FRAC_W-1:0] == rsp_o.fraction, "brr_word does not match mantissa and fraction")

  `UBD_ASSERT(a_stall_holds, rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.brr_word) && $stable(rsp_o.divide_error), "stalled result changed")

  `UBD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !rsp_o.valid, "result valid during reset")

  `UBD_ASSERT(a_cfg_read, psel && !pwrite |-> prdata[APB_DW-1:1] == '0, "config readback has stray bits")

endmodule

bind usart_baud_divisor ubd_checker u_ubd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .rsp_o  (rsp_o),
  .psel   (psel),
  .pwrite (pwrite),
  .prdata (prdata)
);

`default_nettype wire
